// File: hw/rtl/ehm_pkg.sv
package ehm_pkg;

    localparam int RIGHT_DEPTH_DEFAULT = 512;
    localparam int COORD_W             = 12;
    localparam int DESC_W              = 256;
    localparam int DESC_WORD_W         = 64;
    localparam int DIST_W              = 9;
    localparam int INDEX_OUT_W         = 9;

    localparam logic [DIST_W-1:0] LIMIT_RESET = 9'd25;
    localparam logic [DIST_W-1:0] DIST_NONE   = 9'd256;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic REG_DISTANCE_LIMIT = 1'b0;

    // tag that travels with each scanned entry through the distance pipeline
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic [COORD_W-1:0] column;
    } cand_t;

endpackage

// File: hw/rtl/ehm_store.sv
module ehm_store #(
    parameter int RIGHT_DEPTH = ehm_pkg::RIGHT_DEPTH_DEFAULT,
    parameter int IDX_W       = 9
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [IDX_W-1:0]               wr_addr,
    input  logic [2*ehm_pkg::COORD_W-1:0]  wr_coord,
    input  logic [ehm_pkg::DESC_W-1:0]     wr_desc,
    input  logic                           rd_en,
    input  logic [IDX_W-1:0]               rd_addr,
    output logic [2*ehm_pkg::COORD_W-1:0]  rd_coord,
    output logic [ehm_pkg::DESC_W-1:0]     rd_desc
);
    import ehm_pkg::*;

    logic [2*COORD_W-1:0] coord_mem [RIGHT_DEPTH];
    logic [DESC_W-1:0]    desc_mem  [RIGHT_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            coord_mem[wr_addr] <= wr_coord;
            desc_mem[wr_addr]  <= wr_desc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_coord <= coord_mem[rd_addr];
            rd_desc  <= desc_mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/ehm_hamming.sv
module ehm_hamming (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [2*ehm_pkg::COORD_W-1:0] coord,
    input  logic [ehm_pkg::DESC_W-1:0]    desc,
    input  logic [ehm_pkg::COORD_W-1:0]   query_row,
    input  logic [ehm_pkg::COORD_W-1:0]   query_column,
    input  logic [ehm_pkg::DESC_W-1:0]    query_desc,
    output ehm_pkg::cand_t                out_cand,
    output logic [ehm_pkg::DIST_W-1:0]    out_distance
);
    import ehm_pkg::*;

    localparam int WORDS = DESC_W / DESC_WORD_W;

    function automatic logic [6:0] popcount64(input logic [63:0] x);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        logic [63:0] e;
        logic [63:0] f;
        a = (x & {32{2'b01}}) + ((x >> 1) & {32{2'b01}});
        b = (a & {16{4'b0011}}) + ((a >> 2) & {16{4'b0011}});
        c = (b & {8{8'h0F}}) + ((b >> 4) & {8{8'h0F}});
        d = (c & {4{16'h00FF}}) + ((c >> 8) & {4{16'h00FF}});
        e = (d & {2{32'h0000FFFF}}) + ((d >> 16) & {2{32'h0000FFFF}});
        f = (e & {32'h0, 32'hFFFFFFFF}) + (e >> 32);
        return f[6:0];
    endfunction

    logic [DESC_W-1:0] diff;
    cand_t             s1_cand_reg;
    logic [6:0]        pc_reg [WORDS];
    logic [DIST_W-1:0] sum_next;

    assign diff = desc ^ query_desc;

    always_comb
    begin
        sum_next = '0;
        for (int w = 0; w < WORDS; w++)
        begin
            sum_next = sum_next + {2'b00, pc_reg[w]};
        end
    end

    // candidate tag: stage 1 test, stage 2 carried along with the word sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_cand_reg <= '0;
            out_cand    <= '0;
        end
        else
        begin
            s1_cand_reg.valid  <= in_valid;
            s1_cand_reg.hit    <= (coord[2*COORD_W-1:COORD_W] == query_row) &&
                                  (coord[COORD_W-1:0] <= query_column);
            s1_cand_reg.column <= coord[COORD_W-1:0];
            out_cand           <= s1_cand_reg;
        end
    end

    // stage 1: per-word popcount, stage 2: word sums
    always_ff @(posedge clk)
    begin
        for (int w = 0; w < WORDS; w++)
        begin
            pc_reg[w] <= popcount64(diff[w*DESC_WORD_W +: DESC_WORD_W]);
        end
        out_distance <= sum_next;
    end

endmodule

// File: hw/rtl/epipolar_hamming_matcher.sv
// Row-constrained Hamming matcher for stereo keypoints. Op 0 on the input stream clears the
// stored right-image set, op 1 stores one right keypoint (dropped once RIGHT_DEPTH entries are
// held), op 2 queries with a left keypoint and yields one result transaction; ops 0, 1 and 3
// give no result. A query scans the stored entries one per cycle through a single
// registered-read store port and a shared two-stage popcount unit, then drains the unit and
// waits to load its result into the output register, which an older result still waiting
// for m_tready can hold back; an empty set skips the scan. Meanwhile s_tready is low.
// The best candidate has the same row, a column not above the query column and the smallest
// distance; ties go to the smaller column, then the lower index. found is set when that
// distance is at or below distance_limit (APB address 0, reset 25). The finished result sits
// in an output register, so the next transaction is taken while it waits for m_tready.
module epipolar_hamming_matcher #(
    parameter int RIGHT_DEPTH = ehm_pkg::RIGHT_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // row[11:0], column[23:12], desc_w0[87:24], desc_w1[151:88],
    // desc_w2[215:152], desc_w3[279:216]
    input  logic [279:0] s_tdata,
    // op[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // match_index[8:0], match_column[20:9], distance[29:21], zero[31:30]
    output logic [31:0]  m_tdata,
    // found[0]
    output logic [0:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import ehm_pkg::*;

    localparam int IDX_W = (RIGHT_DEPTH > 1) ? $clog2(RIGHT_DEPTH) : 1;
    localparam int CNT_W = $clog2(RIGHT_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     entry_count_reg;
    logic [DIST_W-1:0]    limit_reg;
    logic [IDX_W-1:0]     issue_idx_reg;
    logic [IDX_W-1:0]     eval_idx_reg;
    logic                 rd_valid_reg;
    logic                 have_reg;
    logic                 m_tvalid_reg;

    logic [COORD_W-1:0]   q_row_reg;
    logic [COORD_W-1:0]   q_column_reg;
    logic [DESC_W-1:0]    q_desc_reg;
    logic [DIST_W-1:0]    best_dist_reg;
    logic [COORD_W-1:0]   best_column_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic                 found_reg;
    logic [INDEX_OUT_W-1:0] match_index_reg;
    logic [COORD_W-1:0]   match_column_reg;
    logic [DIST_W-1:0]    distance_reg;

    logic                 s_accept;
    logic [1:0]           op;
    logic                 not_full;
    logic                 wr_en;
    logic                 rd_en;
    logic [2*COORD_W-1:0] rd_coord;
    logic [DESC_W-1:0]    rd_desc;
    cand_t                ham_cand;
    logic [DIST_W-1:0]    ham_distance;
    logic                 better;
    logic                 last_issue;
    logic                 last_eval;
    logic                 out_load;
    logic                 found_next;
    logic [IDX_W+INDEX_OUT_W-1:0] best_idx_wide;
    logic                 cfg_write;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign op         = s_tuser;
    assign not_full   = (entry_count_reg < CNT_W'(RIGHT_DEPTH));
    assign wr_en      = s_accept && (op == OP_LOAD) && not_full;
    assign rd_en      = (state_reg == ST_SCAN);
    assign last_issue = ((CNT_W'(issue_idx_reg) + CNT_W'(1)) == entry_count_reg);
    assign last_eval  = ((CNT_W'(eval_idx_reg) + CNT_W'(1)) == entry_count_reg);
    assign out_load   = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign better     = ham_cand.valid && ham_cand.hit &&
                        (!have_reg || (ham_distance < best_dist_reg) ||
                         ((ham_distance == best_dist_reg) &&
                          (ham_cand.column < best_column_reg)));
    assign found_next    = have_reg && (best_dist_reg <= limit_reg);
    assign best_idx_wide = {{INDEX_OUT_W{1'b0}}, best_idx_reg};
    assign cfg_write     = psel && penable && pwrite && pready;

    ehm_store #(
        .RIGHT_DEPTH (RIGHT_DEPTH),
        .IDX_W       (IDX_W)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (entry_count_reg[IDX_W-1:0]),
        .wr_coord ({s_tdata[11:0], s_tdata[23:12]}),
        .wr_desc  (s_tdata[279:24]),
        .rd_en    (rd_en),
        .rd_addr  (issue_idx_reg),
        .rd_coord (rd_coord),
        .rd_desc  (rd_desc)
    );

    ehm_hamming u_hamming (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (rd_valid_reg),
        .coord        (rd_coord),
        .desc         (rd_desc),
        .query_row    (q_row_reg),
        .query_column (q_column_reg),
        .query_desc   (q_desc_reg),
        .out_cand     (ham_cand),
        .out_distance (ham_distance)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            limit_reg       <= LIMIT_RESET;
            issue_idx_reg   <= '0;
            eval_idx_reg    <= '0;
            rd_valid_reg    <= 1'b0;
            have_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
            if (cfg_write && (paddr[2] == REG_DISTANCE_LIMIT))
            begin
                limit_reg <= pwdata[DIST_W-1:0];
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (ham_cand.valid)
            begin
                eval_idx_reg <= eval_idx_reg + IDX_W'(1);
                if (better)
                begin
                    have_reg <= 1'b1;
                end
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        case (op)
                            OP_CLEAR:
                            begin
                                entry_count_reg <= '0;
                            end
                            OP_LOAD:
                            begin
                                if (not_full)
                                begin
                                    entry_count_reg <= entry_count_reg + CNT_W'(1);
                                end
                            end
                            OP_QUERY:
                            begin
                                issue_idx_reg <= '0;
                                eval_idx_reg  <= '0;
                                have_reg      <= 1'b0;
                                state_reg     <= (entry_count_reg == '0) ? ST_DONE : ST_SCAN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    issue_idx_reg <= issue_idx_reg + IDX_W'(1);
                    if (last_issue)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (ham_cand.valid && last_eval)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && (op == OP_QUERY))
        begin
            q_row_reg     <= s_tdata[11:0];
            q_column_reg  <= s_tdata[23:12];
            q_desc_reg    <= s_tdata[279:24];
            best_dist_reg <= DIST_NONE;
        end
        else if (better)
        begin
            best_dist_reg   <= ham_distance;
            best_column_reg <= ham_cand.column;
            best_idx_reg    <= eval_idx_reg;
        end
        if (out_load)
        begin
            found_reg        <= found_next;
            match_index_reg  <= found_next ? best_idx_wide[INDEX_OUT_W-1:0] : '0;
            match_column_reg <= found_next ? best_column_reg : '0;
            distance_reg     <= best_dist_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, distance_reg, match_column_reg, match_index_reg};
    assign m_tuser  = found_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_DISTANCE_LIMIT) ? {23'd0, limit_reg} : 32'd0;

endmodule
